@@ hdl/bfa_pkg.sv @@
// package with shared types, constants and codes of the block allocator
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

	// default sizing of the block table and the block header
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 24;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;

	// request operation codes
	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FAIL    = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 2'd1;

	// one block table entry
	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [ADDR_W-1:0] size;
		logic              free;
	} entry_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_RESP
	} state_t;

endpackage
`default_nettype wire

@@ hdl/bfa_if.sv @@
// handshake channel interfaces for requests, results and configuration
`timescale 1ns / 1ps
`default_nettype none
interface bfa_req_if;
	logic                      valid;
	logic                      ready;
	logic                      mode;
	logic [bfa_pkg::ADDR_W-1:0] request_size;
	logic [bfa_pkg::ADDR_W-1:0] free_address;

	modport source (output valid, mode, request_size, free_address, input ready);
	modport sink   (input valid, mode, request_size, free_address, output ready);
endinterface

interface bfa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [bfa_pkg::ADDR_W-1:0]   data_address;
	logic [bfa_pkg::STATUS_W-1:0] status;

	modport source (output valid, data_address, status, input ready);
	modport sink   (input valid, data_address, status, output ready);
endinterface

interface bfa_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [bfa_pkg::CFG_IDX_W-1:0] index;
	logic [bfa_pkg::ADDR_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/bfa_table.sv @@
// block table memory with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module bfa_table #(
	parameter int DEPTH = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic            clk,
	input  wire logic            wr_en,
	input  wire logic [IW-1:0]   wr_addr,
	input  wire bfa_pkg::entry_t wr_data,
	input  wire logic            rd_en,
	input  wire logic [IW-1:0]   rd_addr,
	output bfa_pkg::entry_t      rd_data
);

	bfa_pkg::entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ hdl/bfa_ctrl.sv @@
// request sequencer: bump path, table scan and result register
`timescale 1ns / 1ps
`default_nettype none
module bfa_ctrl #(
	parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF,
	parameter int IW           = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	bfa_req_if.sink        req,
	bfa_rsp_if.source      rsp,
	bfa_cfg_if.sink        cfg,
	output bfa_pkg::entry_t tbl_wr_data,
	output logic           tbl_wr_en,
	output logic [IW-1:0]  tbl_wr_addr,
	output logic           tbl_rd_en,
	output logic [IW-1:0]  tbl_rd_addr,
	input  wire bfa_pkg::entry_t tbl_rd_data
);

	localparam int AW = bfa_pkg::ADDR_W;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCKS);
	localparam logic [AW-1:0] HDR     = AW'(HEADER_BYTES);

	bfa_pkg::state_t state_q, state_d;

	// configuration and heap state
	logic [AW-1:0] base_q, bytes_q, nfa_q;
	logic [AW:0]   limit_q;
	logic [CW-1:0] count_q;

	// latched request
	logic            mode_q;
	logic [AW-1:0]   size_q, faddr_q;
	logic [AW+1:0]  end_q;

	// scan pointer and read pipeline
	logic [CW-1:0] scan_q;
	logic          pend_s1;
	logic [IW-1:0] idx_s1;

	// pending result and output register
	logic [AW-1:0]               res_addr_q, out_addr_q;
	logic [bfa_pkg::STATUS_W-1:0] res_st_q, out_st_q;
	logic                        out_valid_q;

	logic req_fire, cfg_fire, rsp_fire;
	logic bump_ok, in_range, hit_s1, last_s1;
	logic finish, do_bump, do_pop, scan_start;
	logic [AW-1:0]               res_addr_d;
	logic [bfa_pkg::STATUS_W-1:0] res_st_d;
	logic [AW-1:0]               rd_daddr;

	// a configuration write takes priority over a request in the same cycle
	assign req.ready = (state_q == bfa_pkg::ST_IDLE) && !cfg.valid;
	assign cfg.ready = (state_q == bfa_pkg::ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign rsp_fire  = rsp.valid && rsp.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.data_address = out_addr_q;
	assign rsp.status       = out_st_q;

	// decisions on the latched request and the returned entry
	assign bump_ok  = (end_q <= {1'b0, limit_q}) && (count_q < MAX_CNT);
	assign in_range = (faddr_q >= base_q) && ({1'b0, faddr_q} <= limit_q);
	assign rd_daddr = tbl_rd_data.start + HDR;
	assign hit_s1   = pend_s1 && ((mode_q == bfa_pkg::MODE_ALLOC)
		? (tbl_rd_data.free && (tbl_rd_data.size >= size_q))
		: (rd_daddr == faddr_q));
	assign last_s1  = (CW'(idx_s1) == (count_q - CW'(1)));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and table access
	always_comb begin
		state_d     = state_q;
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = count_q[IW-1:0];
		tbl_wr_data = '{start: nfa_q, size: size_q, free: 1'b0};
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = scan_q[IW-1:0];
		finish      = 1'b0;
		do_bump     = 1'b0;
		do_pop      = 1'b0;
		scan_start  = 1'b0;
		res_addr_d  = '0;
		res_st_d    = bfa_pkg::STAT_DONE;
		unique case (state_q)
			bfa_pkg::ST_IDLE: begin
				if (req_fire) begin
					state_d = bfa_pkg::ST_DECIDE;
				end
			end
			bfa_pkg::ST_DECIDE: begin
				if (mode_q == bfa_pkg::MODE_ALLOC) begin
					if (bump_ok) begin
						tbl_wr_en  = 1'b1;
						do_bump    = 1'b1;
						finish     = 1'b1;
						res_addr_d = nfa_q + HDR;
					end else begin
						scan_start = 1'b1;
					end
				end else if (in_range) begin
					scan_start = 1'b1;
				end else begin
					finish   = 1'b1;
					res_st_d = bfa_pkg::STAT_IGNORED;
				end
				if (scan_start) begin
					state_d = bfa_pkg::ST_SCAN;
				end
			end
			bfa_pkg::ST_SCAN: begin
				if (hit_s1) begin
					finish      = 1'b1;
					tbl_wr_addr = idx_s1;
					tbl_wr_data = tbl_rd_data;
					if (mode_q == bfa_pkg::MODE_ALLOC) begin
						tbl_wr_en        = 1'b1;
						tbl_wr_data.free = 1'b0;
						res_addr_d       = rd_daddr;
					end else if (last_s1) begin
						do_pop = 1'b1;
					end else begin
						tbl_wr_en        = 1'b1;
						tbl_wr_data.free = 1'b1;
					end
				end else if (scan_q >= count_q) begin
					finish   = 1'b1;
					res_st_d = (mode_q == bfa_pkg::MODE_ALLOC)
						? bfa_pkg::STAT_FAIL : bfa_pkg::STAT_IGNORED;
				end else begin
					tbl_rd_en = 1'b1;
				end
			end
			bfa_pkg::ST_RESP: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = bfa_pkg::ST_IDLE;
				end
			end
			default: state_d = bfa_pkg::ST_IDLE;
		endcase
		if (finish) begin
			state_d = bfa_pkg::ST_RESP;
		end
	end

	// heap registers, rewound by a write to either configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bytes_q <= '0;
			limit_q <= '0;
			nfa_q   <= '0;
			count_q <= '0;
		end else if (cfg_fire) begin
			if (cfg.index == bfa_pkg::REG_HEAP_BASE) begin
				base_q  <= cfg.data;
				limit_q <= {1'b0, cfg.data} + {1'b0, bytes_q};
				nfa_q   <= cfg.data;
				count_q <= '0;
			end else if (cfg.index == bfa_pkg::REG_HEAP_BYTES) begin
				bytes_q <= cfg.data;
				limit_q <= {1'b0, base_q} + {1'b0, cfg.data};
				nfa_q   <= base_q;
				count_q <= '0;
			end
		end else if (do_bump) begin
			nfa_q   <= end_q[AW-1:0];
			count_q <= count_q + CW'(1);
		end else if (do_pop) begin
			nfa_q   <= (count_q == CW'(1)) ? base_q : tbl_rd_data.start;
			count_q <= count_q - CW'(1);
		end
	end

	// request latch and bump end address
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q  <= req.mode;
			size_q  <= req.request_size;
			faddr_q <= req.free_address;
			end_q   <= {2'b00, nfa_q} + {2'b00, HDR} + {2'b00, req.request_size};
		end
	end

	// scan pointer and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			pend_s1 <= 1'b0;
		end else if (scan_start) begin
			scan_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= tbl_rd_en;
			if (tbl_rd_en) begin
				scan_q <= scan_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_rd_en) begin
			idx_s1 <= tbl_rd_addr;
		end
	end

	// pending result
	always_ff @(posedge clk) begin
		if (finish) begin
			res_addr_q <= res_addr_d;
			res_st_q   <= res_st_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == bfa_pkg::ST_RESP && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == bfa_pkg::ST_RESP && (!out_valid_q || rsp.ready)) begin
			out_addr_q <= res_addr_q;
			out_st_q   <= res_st_q;
		end
	end

	// the block count never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("block count beyond table size");

	// a new result only follows a finished request
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == bfa_pkg::ST_RESP))
		else $error("result shown without a finished request");

	// the table is written only while a request is decided or scanned
	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr_en |-> (state_q == bfa_pkg::ST_DECIDE || state_q == bfa_pkg::ST_SCAN))
		else $error("table write outside request handling");

	// the count moves by one per request, or is cleared by a configuration write
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(cfg_fire) |-> (count_q == $past(count_q)
			|| count_q == $past(count_q) + CW'(1)
			|| count_q == $past(count_q) - CW'(1)))
		else $error("block count jumped");

	// no table read is left in flight when a request finishes
	a_scan_stop: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> !tbl_rd_en)
		else $error("table read issued on a finishing cycle");

endmodule
`default_nettype wire

@@ hdl/bump_first_fit_block_allocator.sv @@
// Bump allocator with first-fit reuse over a block table of MAX_BLOCKS entries held in a
// single-port-read memory. Each request takes one transfer in and gives one result transfer
// out. An allocation that fits below heap_base + heap_bytes and finds room in the table is
// placed at the next free address without a table walk. Any other allocation, and every
// free whose address lies inside the heap, walks the table from entry 0 one entry per cycle
// through the memory read port. A free outside the heap is ignored without a walk.
// Requests are handled one at a time; a new request is taken while the previous result
// still waits in the output register. Writing either configuration register restarts the
// heap (empty table, next free address at heap_base). No clearing pass is needed after
// reset.
`timescale 1ns / 1ps
`default_nettype none
module bump_first_fit_block_allocator #(
	parameter int MAX_BLOCKS   = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = bfa_pkg::HEADER_BYTES_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bfa_req_if.sink   req,
	bfa_rsp_if.source rsp,
	bfa_cfg_if.sink   cfg
);

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	bfa_pkg::entry_t tbl_wr_data, tbl_rd_data;
	logic            tbl_wr_en, tbl_rd_en;
	logic [IW-1:0]   tbl_wr_addr, tbl_rd_addr;

	// request sequencer
	bfa_ctrl #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES),
		.IW           (IW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg         (cfg),
		.tbl_wr_data (tbl_wr_data),
		.tbl_wr_en   (tbl_wr_en),
		.tbl_wr_addr (tbl_wr_addr),
		.tbl_rd_en   (tbl_rd_en),
		.tbl_rd_addr (tbl_rd_addr),
		.tbl_rd_data (tbl_rd_data)
	);

	// block table
	bfa_table #(
		.DEPTH (MAX_BLOCKS),
		.IW    (IW)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

endmodule
`default_nettype wire
